// File: rtl/core/poly_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial evaluator package
// Shared types, register indexes and the saturation helper for the evaluator.
// ----------------------------------------------------------------------------
package poly_pkg;

  // Number of coefficient registers and the default highest degree.
  localparam int NUM_COEFS      = 7;
  localparam int MAX_DEGREE_DEF = 6;
  localparam int Q_SHIFT        = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEGREE = 3'd0;
  localparam logic [2:0] REG_COEF0  = 3'd1;

  // One item in flight between two cells.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] acc;
    logic signed [31:0] p;
    logic               ovf;
  } poly_item_t;

  // Forward link between two cells: valid flag and payload.
  typedef struct packed {
    logic       valid;
    poly_item_t item;
  } poly_link_t;

  // Clamp a 49-bit signed value to the signed 32-bit range.
  // The top bit of the result is set when the value was clamped.
  function automatic logic [32:0] sat32(input logic signed [48:0] v);
    logic hi;
    logic lo;
    hi = !v[48] && (|v[47:31]);
    lo = v[48] && !(&v[47:31]);
    if (hi) begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end else if (lo) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, v[31:0]};
    end
  endfunction

endpackage

// File: rtl/core/poly_cell.sv
// ----------------------------------------------------------------------------
// Polynomial evaluator cell
// Adds one power-series term and advances the running power over two stages.
// ----------------------------------------------------------------------------
module poly_cell
  import poly_pkg::*;
#(
  parameter int CELL_IDX = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         degree,
  input  logic signed [31:0] coef,
  input  poly_link_t         up_i,
  output logic               up_ready_o,
  output poly_link_t         dn_o,
  input  logic               dn_ready_i
);

  // Stage A: products
  logic               va_r;
  logic               act_a_r;
  logic signed [31:0] x_a_r;
  logic signed [31:0] acc_a_r;
  logic signed [31:0] p_a_r;
  logic               ovf_a_r;
  logic signed [63:0] prod_c_r;
  logic signed [63:0] prod_p_r;

  // Stage B: updated sums
  logic               vb_r;
  poly_item_t         item_b_r;
  poly_item_t         item_b_nxt;

  logic               ready_a;
  logic               ready_b;
  logic signed [48:0] sum_w;
  logic signed [48:0] pwr_w;
  logic [32:0]        acc_sat;
  logic [32:0]        pwr_sat;

  // Each stage moves when it is empty or its successor takes its request.
  assign ready_b    = !vb_r || dn_ready_i;
  assign ready_a    = !va_r || ready_b;
  assign up_ready_o = ready_a;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= up_i.valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  // Stage A payload: both multiplications in parallel.
  always_ff @(posedge clk) begin
    if (ready_a) begin
      act_a_r  <= (degree >= 3'(CELL_IDX));
      x_a_r    <= up_i.item.x;
      acc_a_r  <= up_i.item.acc;
      p_a_r    <= up_i.item.p;
      ovf_a_r  <= up_i.item.ovf;
      prod_c_r <= coef * up_i.item.p;
      prod_p_r <= up_i.item.p * up_i.item.x;
    end
  end

  // Floor shift, add and clamp; an inactive cell passes the item unchanged.
  always_comb begin
    sum_w   = {{17{acc_a_r[31]}}, acc_a_r} + {prod_c_r[63], prod_c_r[63:Q_SHIFT]};
    pwr_w   = {prod_p_r[63], prod_p_r[63:Q_SHIFT]};
    acc_sat = sat32(sum_w);
    pwr_sat = sat32(pwr_w);
    item_b_nxt.x = x_a_r;
    if (act_a_r) begin
      item_b_nxt.acc = acc_sat[31:0];
      item_b_nxt.p   = pwr_sat[31:0];
      item_b_nxt.ovf = ovf_a_r | acc_sat[32] | pwr_sat[32];
    end else begin
      item_b_nxt.acc = acc_a_r;
      item_b_nxt.p   = p_a_r;
      item_b_nxt.ovf = ovf_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      item_b_r <= item_b_nxt;
    end
  end

  assign dn_o.valid = vb_r;
  assign dn_o.item  = item_b_r;

endmodule

// File: rtl/core/polynomial_evaluator_top.sv
// ----------------------------------------------------------------------------
// Polynomial evaluator
// Evaluates a signed Q16.16 polynomial of up to MAX_DEGREE in power-series order,
// one item per clock while not stalled, through a chain of evaluation cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in_       slave      in_tvalid / in_tready  x_value
//  out_      master     out_tvalid/out_tready  poly_value, overflow
//  cfg_      write      cfg_wr_en              degree, coef_0 .. coef_6
//
// One item is accepted per cycle while the result stream is not stalled; each
// cell has a multiply stage and an add-and-clamp stage, and the output register
// follows the last cell. Every stage holds its own request and moves when its
// successor has room, so bubbles close up during a stall. Reset is synchronous
// and clears the valid flags, the degree and the coefficients.
// ----------------------------------------------------------------------------
module polynomial_evaluator_top
  import poly_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_value
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] poly_value, [32] overflow, [39:33] zero
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [2:0]         degree_r;
  logic signed [31:0] coef_r [NUM_COEFS];
  logic [2:0]         deg_eff;

  poly_link_t         link   [MAX_DEGREE + 1];
  logic               rdy    [MAX_DEGREE + 1];

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_ovf_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_DEGREE) begin
        degree_r <= cfg_wdata[2:0];
      end else begin
        coef_r[3'(cfg_addr - REG_COEF0)] <= cfg_wdata;
      end
    end
  end

  // Degree codes above the cell count use every cell.
  assign deg_eff = (degree_r > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_r;

  // Head of the chain: acc starts at coef_0 and the power at x.
  assign link[0].valid    = in_tvalid;
  assign link[0].item.x   = in_tdata;
  assign link[0].item.acc = coef_r[0];
  assign link[0].item.p   = in_tdata;
  assign link[0].item.ovf = 1'b0;
  assign in_tready        = rdy[0];

  // Chain of cells, one per power.
  for (genvar g = 1; g <= MAX_DEGREE; g++) begin : g_cell
    poly_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .degree     (deg_eff),
      .coef       (coef_r[g]),
      .up_i       (link[g-1]),
      .up_ready_o (rdy[g-1]),
      .dn_o       (link[g]),
      .dn_ready_i (rdy[g])
    );
  end

  // Output register.
  assign rdy[MAX_DEGREE] = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[MAX_DEGREE]) begin
      out_valid_r <= link[MAX_DEGREE].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[MAX_DEGREE]) begin
      out_value_r <= link[MAX_DEGREE].item.acc;
      out_ovf_r   <= link[MAX_DEGREE].item.ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ovf_r, out_value_r};

  // Assertions.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_const_no_ovf : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && deg_eff == 3'd0) |-> !out_ovf_r)
    else $error("overflow reported for a constant polynomial");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result request changed while the receiver stalled");

endmodule

// File: dv/polynomial_evaluator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial evaluator testbench
// Drives x samples into the evaluator under several coefficient settings and
// checks every result, value and overflow flag, against a hand-typed result or a
// fixed-point predictor that walks the power series the same way the hardware does.
// ----------------------------------------------------------------------------
module polynomial_evaluator_top_test;
  import poly_pkg::*;

  localparam int TOP_DEGREE    = MAX_DEGREE_DEF;
  localparam int DRAIN_CYCLES  = 2 * TOP_DEGREE + 1 + 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  // One result: polynomial value and overflow flag.
  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } poly_res_t;

  // Result typed in by hand for a directed request, when there is one.
  typedef struct {
    bit        given;
    poly_res_t res;
  } typed_res_t;

  // Row of the directed table; set selects the coefficient setting.
  typedef struct {
    int unsigned set_id;
    logic [31:0] x;
    bit          given;
    logic [31:0] value;
    logic        ovf;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [31:0] cfg_wdata  = '0;

  // Predictor copy of the configuration registers.
  logic [2:0]         degree_shadow = '0;
  logic signed [31:0] coef_shadow [NUM_COEFS];

  poly_res_t   poly_expect_q [$];
  typed_res_t  typed_q [$];
  row_t        rows [$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  bit          long_hold      = 1'b0;

  polynomial_evaluator_top #(
    .MAX_DEGREE(TOP_DEGREE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp to signed 32 bits; bit 32 tells whether the value was clamped.
  function automatic logic [32:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Evaluate the polynomial at x in power-series order, with the power
  // updated after every term, the last one included.
  function automatic poly_res_t eval_poly(input logic [31:0] x);
    longint      xs;
    longint      acc;
    longint      pw;
    logic [32:0] c;
    logic        ovf;
    int          deg;
    poly_res_t   r;
    xs  = longint'($signed(x));
    acc = longint'(coef_shadow[0]);
    pw  = xs;
    ovf = 1'b0;
    deg = (degree_shadow > TOP_DEGREE) ? TOP_DEGREE : int'(degree_shadow);
    for (int i = 1; i <= deg; i++) begin
      c   = clamp32(acc + ((longint'(coef_shadow[i]) * pw) >>> Q_SHIFT));
      ovf = ovf | c[32];
      acc = longint'($signed(c[31:0]));
      c   = clamp32((pw * xs) >>> Q_SHIFT);
      ovf = ovf | c[32];
      pw  = longint'($signed(c[31:0]));
    end
    r.value = acc[31:0];
    r.ovf   = ovf;
    return r;
  endfunction

  // Mix of extremes, full-range words and small Q16.16 values of +/- span.
  function automatic logic [31:0] rand_fixed(input int unsigned span);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (kind <= 3) begin
      return $urandom;
    end
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic add_row(input int unsigned set_id, input logic [31:0] x,
                         input bit given, input logic [31:0] value, input logic ovf);
    row_t r;
    r.set_id = set_id;
    r.x      = x;
    r.given  = given;
    r.value  = value;
    r.ovf    = ovf;
    rows.push_back(r);
  endtask

  // Write the degree and all coefficients, one register per cycle.
  task automatic load_config(input logic [2:0] deg, input logic [6:0][31:0] coefs);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_DEGREE;
    cfg_wdata <= 32'(deg);
    degree_shadow = deg;
    for (int i = 0; i < NUM_COEFS; i++) begin
      @(negedge clk);
      cfg_addr  <= REG_COEF0 + 3'(i);
      cfg_wdata <= coefs[i];
      coef_shadow[i] = coefs[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one x sample and return once the request has been accepted.
  task automatic send_x(input logic [31:0] x, input bit given, input poly_res_t res);
    typed_res_t t;
    t.given = given;
    t.res   = res;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_q.push_back(t);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop the request line and wait until every result is back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (poly_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input poly_res_t want,
                               input poly_res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected value %h ovf %b, got value %h ovf %b",
               $realtime, what, want.value, want.ovf, got.value, got.ovf);
    end
  endtask

  // Sets the per-phase idling: none, sender, receiver, both lightly.
  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
      default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
    endcase
  endtask

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk) begin : scoreboard
    typed_res_t t;
    poly_res_t  want;
    poly_res_t  got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (typed_q.size() != 0) begin
          t = typed_q.pop_front();
        end else begin
          t.given = 1'b0;
          t.res   = '0;
        end
        want = t.given ? t.res : eval_poly(in_tdata);
        poly_expect_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[31:0];
        got.ovf   = out_tdata[32];
        if (poly_expect_q.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got);
        end else begin
          want = poly_expect_q.pop_front();
          if (got.value != want.value) note_mismatch("poly_value", want, got);
          if (got.ovf != want.ovf) note_mismatch("overflow", want, got);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        long_hold = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    int unsigned       cur_set;
    logic [2:0]        deg;
    logic [6:0][31:0]  coefs;
    for (int i = 0; i < NUM_COEFS; i++) coef_shadow[i] = '0;

    // After reset every coefficient is zero.
    add_row(0, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    add_row(0, 32'h7FFF_FFFF, 1, 32'h0000_0000, 1'b0);
    add_row(0, 32'h8000_0000, 1, 32'h0000_0000, 1'b0);
    // Identity line; the unused final power still flags overflow.
    add_row(1, 32'h0001_0000, 1, 32'h0001_0000, 1'b0);
    add_row(1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b1);
    add_row(1, 32'h8000_0000, 1, 32'h8000_0000, 1'b1);
    add_row(1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0);
    // Degree code above the top degree, extreme coefficients.
    add_row(2, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1'b0);
    add_row(2, 32'h0001_0000, 0, '0, 1'b0);
    add_row(2, 32'hFFFF_0000, 0, '0, 1'b0);
    add_row(2, 32'h7FFF_FFFF, 0, '0, 1'b0);
    // Tiny coefficients: rounding toward minus infinity on negative terms.
    add_row(3, 32'hFFFF_FFFF, 0, '0, 1'b0);
    add_row(3, 32'h0000_0001, 0, '0, 1'b0);
    add_row(3, 32'hFFFE_0000, 0, '0, 1'b0);
    add_row(3, 32'h0002_0000, 0, '0, 1'b0);
    // Sum clamps at the negative end.
    add_row(4, 32'h0001_0000, 1, 32'h8000_0000, 1'b1);
    add_row(4, 32'h8000_0000, 0, '0, 1'b0);
    // Mixed full-degree polynomial.
    add_row(5, 32'h0000_8000, 0, '0, 1'b0);
    add_row(5, 32'hFFFF_8000, 0, '0, 1'b0);
    add_row(5, 32'h0003_0000, 0, '0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    set_idling(0);
    cur_set = 0;
    foreach (rows[k]) begin
      if (rows[k].set_id != cur_set) begin
        wait_drained();
        coefs = '0;
        case (rows[k].set_id)
          1: begin
            deg      = 3'd1;
            coefs[1] = 32'h0001_0000;
          end
          2: begin
            deg = 3'd7;
            coefs[0] = 32'h7FFF_FFFF;
            for (int i = 1; i < NUM_COEFS; i++) coefs[i] = 32'h8000_0000;
          end
          3: begin
            deg = 3'd6;
            for (int i = 1; i < NUM_COEFS; i++) coefs[i] = 32'h0000_0001;
          end
          4: begin
            deg      = 3'd2;
            coefs[0] = 32'h8000_0000;
            coefs[1] = 32'h8000_0000;
          end
          default: begin
            deg   = 3'd6;
            coefs = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_4000, 32'hFFFE_8000,
                     32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000};
          end
        endcase
        load_config(deg, coefs);
        cur_set = rows[k].set_id;
      end
      send_x(rows[k].x, rows[k].given, {rows[k].value, rows[k].ovf});
    end

    // Random part: a fresh setting and idling pattern per phase.
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0:       deg = 3'd0;
        1:       deg = 3'd6;
        2:       deg = 3'd7;
        3:       deg = 3'd1;
        default: deg = 3'($urandom_range(0, 7));
      endcase
      for (int i = 0; i < NUM_COEFS; i++) coefs[i] = rand_fixed(32'h0004_0000);
      load_config(deg, coefs);
      set_idling(ph % 4);
      repeat (PHASE_ITEMS) send_x(rand_fixed(32'h0002_0000), 1'b0, '0);
    end

    // Back-pressure: results held off while the sender keeps offering.
    wait_drained();
    for (int i = 0; i < NUM_COEFS; i++) coefs[i] = rand_fixed(32'h0004_0000);
    load_config(3'd6, coefs);
    set_idling(0);
    long_hold = 1'b1;
    repeat (60) send_x(rand_fixed(32'h0002_0000), 1'b0, '0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
